/* src/tte_pkg.sv */
// ---------------------------------------------------------------------------
// Tab expander package
// Shared widths, character codes, configuration and unit interface types.
// ---------------------------------------------------------------------------
package tte_pkg;

   localparam int MAX_STOPS   = 6;
   localparam int COLUMN_BITS = 16;
   localparam int STOP_BITS   = 7;
   localparam int COUNT_BITS  = 3;
   localparam int INDEX_BITS  = 3;
   localparam int BYTE_BITS   = 8;
   localparam int STOP_LIMIT  = 64;

   // Character codes
   localparam logic [BYTE_BITS-1:0] CH_BS    = 8'd8;
   localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'd9;
   localparam logic [BYTE_BITS-1:0] CH_NL    = 8'd10;
   localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'd32;

   // Register indexes
   localparam logic [INDEX_BITS-1:0] REG_LEADING_ONLY = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_STOP_COUNT   = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_TAB_STOP_0   = 3'd2;

   typedef struct packed {
      logic                                 leading_only;
      logic [COUNT_BITS-1:0]                stop_count;  // already clamped to 1..MAX_STOPS
      logic [MAX_STOPS-1:0][STOP_BITS-1:0]  stops;       // raw values, clamped where used
   } cfg_type;

   typedef struct packed {
      logic                   start;
      logic [COLUMN_BITS-1:0] dividend;
      logic [STOP_BITS-1:0]   divisor;
   } rem_req_type;

   typedef struct packed {
      logic                 done;
      logic [STOP_BITS-1:0] remainder;
   } rem_rsp_type;

   // Zero reads as one, anything past the limit as the limit
   function automatic logic [STOP_BITS-1:0] stop_clamp(input logic [STOP_BITS-1:0] v);
      logic [STOP_BITS-1:0] r;
      if (v == '0) begin
         r = STOP_BITS'(1);
      end else if (v > STOP_BITS'(STOP_LIMIT)) begin
         r = STOP_BITS'(STOP_LIMIT);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [COUNT_BITS-1:0] count_clamp(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      if (v == '0) begin
         r = COUNT_BITS'(1);
      end else if (v > COUNT_BITS'(MAX_STOPS)) begin
         r = COUNT_BITS'(MAX_STOPS);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Saturating column advance
   function automatic logic [COLUMN_BITS-1:0] col_add(input logic [COLUMN_BITS-1:0] c,
                                                      input logic [STOP_BITS-1:0]   n);
      logic [COLUMN_BITS:0]   sum;
      logic [COLUMN_BITS-1:0] r;
      sum = {1'b0, c} + {{(COLUMN_BITS+1-STOP_BITS){1'b0}}, n};
      if (sum[COLUMN_BITS]) begin
         r = '1;
      end else begin
         r = sum[COLUMN_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* src/tte_rem_unit.sv */
// ---------------------------------------------------------------------------
// Tab expander remainder unit
// Restoring remainder of the column by the tab width, one bit per cycle.
// ---------------------------------------------------------------------------
module tte_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  tte_pkg::rem_req_type rem_req,
   output tte_pkg::rem_rsp_type rem_rsp
);
   import tte_pkg::*;

   localparam int CNT_BITS = $clog2(COLUMN_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [COLUMN_BITS-1:0] shift_ff, shift_in;
   logic [STOP_BITS-1:0]   rem_ff, rem_in;
   logic [STOP_BITS-1:0]   divisor_ff, divisor_in;
   logic [STOP_BITS-1:0]   trial;

   // One shift-compare-subtract step per cycle
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      // remainder stays below the divisor (at most 64), so six bits carry it
      trial      = {rem_ff[STOP_BITS-2:0], shift_ff[COLUMN_BITS-1]};
      if (rem_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_BITS'(COLUMN_BITS);
         shift_in   = rem_req.dividend;
         rem_in     = '0;
         divisor_in = rem_req.divisor;
      end else if (busy_ff) begin
         rem_in   = (trial >= divisor_ff) ? (trial - divisor_ff) : trial;
         shift_in = {shift_ff[COLUMN_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rem_rsp.done      = done_ff;
   assign rem_rsp.remainder = rem_ff;

   // Checks
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("remainder not below divisor");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !rem_req.start)
      else $error("remainder unit restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");

endmodule

/* src/tte_seq.sv */
// ---------------------------------------------------------------------------
// Tab expander sequencer
// Column tracking, tab stop search, space emission and the output register.
// ---------------------------------------------------------------------------
module tte_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  tte_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tte_pkg::BYTE_BITS-1:0]   req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tte_pkg::BYTE_BITS-1:0]   rsp_out_byte,
   output logic                            rsp_last_of_run,
   output tte_pkg::rem_req_type            rem_req,
   input  tte_pkg::rem_rsp_type            rem_rsp
);
   import tte_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic                   line_start_ff, line_start_in;
   logic                   expand_ff, expand_in;
   logic [INDEX_BITS-1:0]  k_ff, k_in;
   logic [STOP_BITS-1:0]   dist_ff, dist_in;
   logic [STOP_BITS-1:0]   remain_ff, remain_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_BITS-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   slot_free;
   logic                   req_fire;
   logic [STOP_BITS-1:0]   width;
   logic [STOP_BITS-1:0]   stop_k;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign width     = stop_clamp(cfg.stops[0]);
   assign stop_k    = stop_clamp(cfg.stops[k_ff]);

   // Next state
   always_comb begin
      state_in      = state_ff;
      column_in     = column_ff;
      line_start_in = line_start_ff;
      expand_in     = expand_ff;
      k_in          = k_ff;
      dist_in       = dist_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      rem_req.start    = 1'b0;
      rem_req.dividend = column_ff;
      rem_req.divisor  = width;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_in_byte == CH_TAB) begin
                  expand_in = line_start_ff || !cfg.leading_only;
                  if (cfg.stop_count == COUNT_BITS'(1)) begin
                     rem_req.start = 1'b1;
                     state_in      = S_DIV;
                  end else begin
                     k_in     = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_in_byte;
                  rsp_last_in  = 1'b1;
                  case (req_in_byte)
                     CH_BS: begin
                        line_start_in = 1'b0;
                        if (column_ff != '0) begin
                           column_in = column_ff - COLUMN_BITS'(1);
                        end
                     end
                     CH_NL: begin
                        line_start_in = 1'b1;
                        column_in     = '0;
                     end
                     default: begin
                        column_in = col_add(column_ff, STOP_BITS'(1));
                        if (req_in_byte != CH_SPACE) begin
                           line_start_in = 1'b0;
                        end
                     end
                  endcase
               end
            end
         end
         // repeating width: distance is width minus column mod width
         S_DIV: begin
            if (rem_rsp.done) begin
               dist_in   = width - rem_rsp.remainder;
               remain_in = width - rem_rsp.remainder;
               state_in  = S_EMIT;
            end
         end
         // explicit stops: first stop past the column, else one column
         S_SCAN: begin
            if (column_ff < {{(COLUMN_BITS-STOP_BITS){1'b0}}, stop_k}) begin
               dist_in   = stop_k - column_ff[STOP_BITS-1:0];
               remain_in = stop_k - column_ff[STOP_BITS-1:0];
               state_in  = S_EMIT;
            end else if (k_ff == cfg.stop_count - COUNT_BITS'(1)) begin
               dist_in   = STOP_BITS'(1);
               remain_in = STOP_BITS'(1);
               state_in  = S_EMIT;
            end else begin
               k_in = k_ff + INDEX_BITS'(1);
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (expand_ff) begin
                  rsp_byte_in = CH_SPACE;
                  rsp_last_in = (remain_ff == STOP_BITS'(1));
                  remain_in   = remain_ff - STOP_BITS'(1);
                  if (remain_ff == STOP_BITS'(1)) begin
                     column_in = col_add(column_ff, dist_ff);
                     state_in  = S_IDLE;
                  end
               end else begin
                  rsp_byte_in = CH_TAB;
                  rsp_last_in = 1'b1;
                  column_in   = col_add(column_ff, dist_ff);
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         column_ff     <= '0;
         line_start_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         column_ff     <= column_in;
         line_start_ff <= line_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      expand_ff   <= expand_in;
      k_ff        <= k_in;
      dist_ff     <= dist_in;
      remain_ff   <= remain_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Checks
   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (remain_ff != '0))
      else $error("emitting with nothing left to send");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_in_byte == CH_NL) |=> (column_ff == '0) && line_start_ff)
      else $error("newline did not reset the column");

   a_tab_keeps_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(line_start_ff))
      else $error("line start flag changed during a tab");

endmodule

/* src/tab_to_space_expander_core.sv */
// ---------------------------------------------------------------------------
// Tab to space expander
// Top level: configuration registers, sequencer and remainder unit.
// ---------------------------------------------------------------------------
// An ordinary byte (anything but a tab) is taken when the output register is
// free and leaves through that register the next cycle, so plain text streams
// at one byte per cycle while the output side does not stall. A tab holds the
// input off while its target is found and its spaces go out: with one stop
// (repeating width) the column is reduced modulo the width by a bit-serial
// remainder unit, one column bit per step, which then hands the result back;
// with several stops the stops are compared against the column one per cycle;
// then the spaces leave at one per cycle, 1 to 64 of them, while the output
// side does not stall.
module tab_to_space_expander_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tte_pkg::BYTE_BITS-1:0]        req_in_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tte_pkg::BYTE_BITS-1:0]        rsp_out_byte,
   output logic                                 rsp_last_of_run,
   input  logic                                 csr_we,
   input  logic [tte_pkg::INDEX_BITS-1:0]       csr_index,
   input  logic [tte_pkg::STOP_BITS-1:0]        csr_wdata
);
   import tte_pkg::*;

   logic                                leading_only_ff;
   logic [COUNT_BITS-1:0]               stop_count_ff;
   logic [MAX_STOPS-1:0][STOP_BITS-1:0] tab_stop_ff;
   cfg_type                             cfg;
   rem_req_type                         rem_req;
   rem_rsp_type                         rem_rsp;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         leading_only_ff <= 1'b0;
         stop_count_ff   <= COUNT_BITS'(1);
         for (int i = 0; i < MAX_STOPS; i++) begin
            tab_stop_ff[i] <= STOP_BITS'(8 * (i + 1));
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEADING_ONLY: leading_only_ff <= csr_wdata[0];
            REG_STOP_COUNT:   stop_count_ff   <= csr_wdata[COUNT_BITS-1:0];
            default: begin
               tab_stop_ff[csr_index - REG_TAB_STOP_0] <= csr_wdata;
            end
         endcase
      end
   end

   // View for the sequencer, with the stop count clamped
   always_comb begin
      cfg.leading_only = leading_only_ff;
      cfg.stop_count   = count_clamp(stop_count_ff);
      cfg.stops        = tab_stop_ff;
   end

   tte_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rem_req         (rem_req),
      .rem_rsp         (rem_rsp)
   );

   tte_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

endmodule

/* sim/tb_tab_to_space_expander_core.sv */
// ---------------------------------------------------------------------------
// Tab to space expander testbench
// Drives text bytes into the expander and checks every output byte and its
// end-of-run flag against the directed table's expectations or a cycle-free
// predictor of the column and line-start logic. A short directed table comes
// first, then a long line that walks the column well past one tab width, then
// random text under a series of tab stop settings. Both sides idle in random
// bursts except in the third phase and the closing phases.
// ---------------------------------------------------------------------------
module tb_tab_to_space_expander_core;
   timeunit 1ns;
   timeprecision 1ps;

   import tte_pkg::*;

   localparam int COL_MAX     = (1 << COLUMN_BITS) - 1;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int TAIL_CYCLES = 100;
   localparam int NUM_REGS    = 2 + MAX_STOPS;
   localparam int NUM_PHASES  = 9;
   localparam int FIXED_PHASES = 7;
   localparam int PHASE_BYTES = 35;
   localparam int LONG_LINE_TABS = 12;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last;
   } out_item_type;

   typedef enum logic {ROW_BYTE, ROW_REG} row_kind_type;

   // One line of the directed plan: a byte request or a register write.
   // Where typed is set, n_out copies of out are expected.
   typedef struct packed {
      row_kind_type         kind;
      logic [INDEX_BITS-1:0] index;
      logic [BYTE_BITS-1:0] value;
      logic                 typed;
      logic [6:0]           n_out;
      logic [BYTE_BITS-1:0] out;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_BITS-1:0]   req_in_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_BITS-1:0]   rsp_out_byte;
   logic                   rsp_last_of_run;
   logic                   csr_we = 1'b0;
   logic [INDEX_BITS-1:0]  csr_index = '0;
   logic [STOP_BITS-1:0]   csr_wdata = '0;

   // Predictor state and its copy of the registers
   logic [COLUMN_BITS-1:0] col_now = '0;
   logic                   line_blank = 1'b1;
   logic                   lead_only_cfg = 1'b0;
   logic [COUNT_BITS-1:0]  stop_cnt_cfg = COUNT_BITS'(1);
   logic [STOP_BITS-1:0]   stop_cfg [MAX_STOPS];

   out_item_type           expected_bytes [$];
   int                     mismatch_count = 0;
   int                     cycle_count = 0;
   int                     hold_cycles = 0;
   bit                     idle_en = 1'b1;

   plan_row_type directed_plan [0:26] = '{
      // reset settings: width 8, expand everywhere
      '{ROW_BYTE, '0, CH_TAB,   1'b1, 7'd8, CH_SPACE},
      '{ROW_BYTE, '0, 8'h61,    1'b1, 7'd1, 8'h61},
      '{ROW_BYTE, '0, CH_TAB,   1'b1, 7'd7, CH_SPACE},
      '{ROW_BYTE, '0, CH_BS,    1'b1, 7'd1, CH_BS},
      '{ROW_BYTE, '0, CH_TAB,   1'b1, 7'd1, CH_SPACE},
      '{ROW_BYTE, '0, 8'h00,    1'b1, 7'd1, 8'h00},
      '{ROW_BYTE, '0, 8'hFF,    1'b1, 7'd1, 8'hFF},
      '{ROW_BYTE, '0, CH_SPACE, 1'b1, 7'd1, CH_SPACE},
      '{ROW_BYTE, '0, CH_NL,    1'b1, 7'd1, CH_NL},
      // backspace at column zero leaves it there
      '{ROW_BYTE, '0, CH_BS,    1'b1, 7'd1, CH_BS},
      '{ROW_BYTE, '0, CH_TAB,   1'b1, 7'd8, CH_SPACE},
      // leading-only with three explicit stops
      '{ROW_REG, REG_LEADING_ONLY,                  8'd1,  1'b0, 7'd0, 8'h00},
      '{ROW_REG, REG_STOP_COUNT,                    8'd3,  1'b0, 7'd0, 8'h00},
      '{ROW_REG, REG_TAB_STOP_0,                    8'd4,  1'b0, 7'd0, 8'h00},
      '{ROW_REG, INDEX_BITS'(REG_TAB_STOP_0 + 1),   8'd10, 1'b0, 7'd0, 8'h00},
      '{ROW_REG, INDEX_BITS'(REG_TAB_STOP_0 + 2),   8'd20, 1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_NL,    1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_SPACE, 1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_TAB,   1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, 8'h78,    1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_TAB,   1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_TAB,   1'b0, 7'd0, 8'h00},
      // past the last stop
      '{ROW_BYTE, '0, CH_TAB,   1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_BS,    1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_NL,    1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, CH_TAB,   1'b0, 7'd0, 8'h00},
      '{ROW_BYTE, '0, 8'h80,    1'b0, 7'd0, 8'h00}
   };

   // Register values per phase: leading_only, stop_count, six stops
   logic [STOP_BITS-1:0] phase_regs [0:FIXED_PHASES-1][0:NUM_REGS-1] = '{
      '{7'd0, 7'd1, 7'd1,   7'd16, 7'd24, 7'd32,  7'd40, 7'd48},
      '{7'd1, 7'd1, 7'd64,  7'd16, 7'd24, 7'd32,  7'd40, 7'd48},
      '{7'd0, 7'd6, 7'd3,   7'd9,  7'd17, 7'd30,  7'd45, 7'd64},
      '{7'd1, 7'd0, 7'd0,   7'd5,  7'd6,  7'd7,   7'd8,  7'd9},
      '{7'd0, 7'd7, 7'd127, 7'd5,  7'd0,  7'd100, 7'd12, 7'd70},
      '{7'd1, 7'd2, 7'd1,   7'd2,  7'd4,  7'd5,   7'd6,  7'd7},
      '{7'd0, 7'd1, 7'd5,   7'd16, 7'd24, 7'd32,  7'd40, 7'd48}
   };

   logic [BYTE_BITS-1:0] long_line_tail [0:6] = '{
      CH_TAB, CH_TAB, 8'h62, CH_BS, CH_TAB, CH_TAB, CH_NL
   };

   tab_to_space_expander_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Columns from the current column to the target stop
   function automatic int tab_span();
      int n;
      int w;
      int s;
      n = (stop_cnt_cfg == 0) ? 1 : int'(stop_cnt_cfg);
      if (n > MAX_STOPS) n = MAX_STOPS;
      if (n == 1) begin
         w = (stop_cfg[0] == 0) ? 1 : int'(stop_cfg[0]);
         if (w > STOP_LIMIT) w = STOP_LIMIT;
         return w - (int'(col_now) % w);
      end
      for (int k = 0; k < n; k++) begin
         s = (stop_cfg[k] == 0) ? 1 : int'(stop_cfg[k]);
         if (s > STOP_LIMIT) s = STOP_LIMIT;
         if (int'(col_now) < s) return s - int'(col_now);
      end
      return 1;
   endfunction

   function automatic logic [COLUMN_BITS-1:0] col_advance(input int n);
      int sum;
      sum = int'(col_now) + n;
      return (sum > COL_MAX) ? COLUMN_BITS'(COL_MAX) : COLUMN_BITS'(sum);
   endfunction

   // Advance the predicted state by one byte, queueing its output if asked
   task automatic predict_expansion(input logic [BYTE_BITS-1:0] b, input bit keep);
      int span;
      if (b == CH_TAB) begin
         span = tab_span();
         if (keep) begin
            if (line_blank || !lead_only_cfg) begin
               for (int k = 0; k < span; k++)
                  expected_bytes.push_back('{out_byte: CH_SPACE, last: (k == span - 1)});
            end else begin
               expected_bytes.push_back('{out_byte: CH_TAB, last: 1'b1});
            end
         end
         col_now = col_advance(span);
      end else begin
         if (b == CH_BS) begin
            line_blank = 1'b0;
            if (col_now != 0) col_now = col_now - COLUMN_BITS'(1);
         end else if (b == CH_NL) begin
            line_blank = 1'b1;
            col_now = '0;
         end else begin
            col_now = col_advance(1);
            if (b != CH_SPACE) line_blank = 1'b0;
         end
         if (keep) expected_bytes.push_back('{out_byte: b, last: 1'b1});
      end
   endtask

   // Offer one byte request and wait for it to be taken
   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit typed = 1'b0,
                            input logic [6:0] n_out = '0,
                            input logic [BYTE_BITS-1:0] out = '0);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_expansion(b, !typed);
      if (typed) begin
         for (int k = 0; k < int'(n_out); k++)
            expected_bytes.push_back('{out_byte: out, last: (k == int'(n_out) - 1)});
      end
   endtask

   // Stop requesting and let every expected byte drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                            input logic [STOP_BITS-1:0] data);
      case (idx)
         REG_LEADING_ONLY: lead_only_cfg = data[0];
         REG_STOP_COUNT:   stop_cnt_cfg  = data[COUNT_BITS-1:0];
         default:          stop_cfg[idx - REG_TAB_STOP_0] = data;
      endcase
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [BYTE_BITS-1:0] random_text_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return CH_TAB;
      if (pick < 42) return CH_SPACE;
      if (pick < 50) return CH_NL;
      if (pick < 58) return CH_BS;
      if (pick < 88) return BYTE_BITS'($urandom_range(8'h21, 8'h7E));
      return BYTE_BITS'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s expected %0h actual %0h",
                  cycle_count, what, want, got);
   endtask

   // Output side stalls in random bursts
   always @(posedge clock) begin
      if (reset || !idle_en) begin
         hold_cycles = 0;
         rsp_ready <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         hold_cycles = $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted output byte with the oldest expectation
   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", -1, int'(rsp_out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(want.out_byte), int'(rsp_out_byte));
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", int'(want.last), int'(rsp_last_of_run));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < MAX_STOPS; k++) stop_cfg[k] = STOP_BITS'(8 * (k + 1));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_REG) begin
            wait_idle();
            write_reg(directed_plan[r].index, directed_plan[r].value[STOP_BITS-1:0]);
         end else begin
            send_byte(directed_plan[r].value, directed_plan[r].typed,
                      directed_plan[r].n_out, directed_plan[r].out);
         end
      end

      // long line: pass-through tabs of width 64 carry the column far out,
      // then expanded tabs of width 7 reduce a large column
      wait_idle();
      write_reg(REG_LEADING_ONLY, 7'd1);
      write_reg(REG_STOP_COUNT, 7'd1);
      write_reg(REG_TAB_STOP_0, 7'd64);
      send_byte(CH_NL);
      send_byte(8'h61);
      for (int k = 0; k < LONG_LINE_TABS; k++) send_byte(CH_TAB);
      wait_idle();
      write_reg(REG_LEADING_ONLY, 7'd0);
      write_reg(REG_TAB_STOP_0, 7'd7);
      foreach (long_line_tail[k]) send_byte(long_line_tail[k]);

      // random text under each setting; no idling at the close
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         idle_en = (ph != 2) && (ph < FIXED_PHASES);
         for (int idx = 0; idx < NUM_REGS; idx++)
            write_reg(INDEX_BITS'(idx), (ph < FIXED_PHASES) ? phase_regs[ph][idx]
                                                            : STOP_BITS'($urandom_range(0, 127)));
         for (int k = 0; k < PHASE_BYTES; k++) send_byte(random_text_byte());
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* tab_to_space_expander_core.f */
src/tte_pkg.sv
src/tte_rem_unit.sv
src/tte_seq.sv
src/tab_to_space_expander_core.sv
sim/tb_tab_to_space_expander_core.sv
